// File: src/brbp_pkg.sv
// ----------------------------------------------------------------------------
// brbp_pkg
// Shared types and constants for the banked byte RAM with bitmap projection.
// ----------------------------------------------------------------------------
package brbp_pkg;

    // access commands
    localparam logic [1:0] CMD_HOST_RD = 2'd0;
    localparam logic [1:0] CMD_HOST_WR = 2'd1;
    localparam logic [1:0] CMD_COP_RD  = 2'd2;
    localparam logic [1:0] CMD_COP_WR  = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 7;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOST_BANK   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COP_BANK    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BITMAP_MODE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TWO_BPP     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAM_PRESENT = 3'd4;

    // host window that gets banked
    localparam logic [23:0] HOST_WINDOW = 24'h002000;

    // pixel masks before shifting
    localparam logic [7:0] PIX4_MASK = 8'h0f;
    localparam logic [7:0] PIX2_MASK = 8'h03;

    // configuration state
    typedef struct packed {
        logic [4:0] host_bank;
        logic [6:0] cop_bank;
        logic       bitmap_mode;
        logic       two_bpp;
        logic       ram_present;
    } t_cfg;

    // decoded access, handed from the address mapper to the sequencer
    typedef struct packed {
        logic       is_read;
        logic       is_pixel;
        logic       two_bpp;
        logic [1:0] pix_sel;
    } t_acc_info;

endpackage

// File: src/brbp_addr_map.sv
// ----------------------------------------------------------------------------
// brbp_addr_map
// Maps a port address to a mirrored RAM byte address and a pixel selector.
// ----------------------------------------------------------------------------
module brbp_addr_map
    import brbp_pkg::*;
#(
    parameter int unsigned RAM_ADDR_BITS = 18
) (
    input  logic [1:0]               i_cmd,
    input  logic [23:0]              i_address,
    input  t_cfg                     i_cfg,
    output logic [RAM_ADDR_BITS-1:0] o_addr,
    output t_acc_info                o_info
);

    logic [23:0] w_host_a;
    logic [23:0] w_lin_a;
    logic [19:0] w_bm_a;
    logic [23:0] w_pix_a;
    logic [23:0] w_full_a;
    logic        w_is_cop;

    assign w_is_cop = (i_cmd == CMD_COP_RD) || (i_cmd == CMD_COP_WR);

    // host: only the low window is banked
    assign w_host_a = (i_address < HOST_WINDOW)
                    ? {6'd0, i_cfg.host_bank, i_address[12:0]}
                    : i_address;

    // coprocessor linear: low 5 bank bits
    assign w_lin_a = {6'd0, i_cfg.cop_bank[4:0], i_address[12:0]};

    // coprocessor bitmap: full bank, then split into byte and pixel
    assign w_bm_a  = {i_cfg.cop_bank, i_address[12:0]};
    assign w_pix_a = i_cfg.two_bpp ? {6'd0, w_bm_a[19:2]}
                                   : {5'd0, w_bm_a[19:1]};

    always_comb begin
        if (!w_is_cop) begin
            w_full_a = w_host_a;
        end else if (!i_cfg.bitmap_mode) begin
            w_full_a = w_lin_a;
        end else begin
            w_full_a = w_pix_a;
        end
    end

    // mirror to the fitted RAM size
    assign o_addr = w_full_a[RAM_ADDR_BITS-1:0];

    assign o_info.is_read  = (i_cmd == CMD_HOST_RD) || (i_cmd == CMD_COP_RD);
    assign o_info.is_pixel = w_is_cop && i_cfg.bitmap_mode;
    assign o_info.two_bpp  = i_cfg.two_bpp;
    assign o_info.pix_sel  = i_cfg.two_bpp ? w_bm_a[1:0] : {1'b0, w_bm_a[0]};

endmodule

// File: src/brbp_ram.sv
// ----------------------------------------------------------------------------
// brbp_ram
// Single-port byte RAM with a registered read port.
// ----------------------------------------------------------------------------
module brbp_ram #(
    parameter int unsigned ADDR_BITS = 18
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [7:0]           i_wdata,
    output logic [7:0]           o_rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/banked_ram_bitmap_projection_top.sv
// ----------------------------------------------------------------------------
// banked_ram_bitmap_projection_top
// Banked byte RAM with host and coprocessor ports and packed pixel access.
// ----------------------------------------------------------------------------
// Each transaction is accepted in the idle state, where the mapped byte is read
// from the single-port RAM; in the execute state that follows, the read result is
// formed or the byte (plain, or with one pixel replaced) is written back.
// The execute state waits while the output register still holds an untaken
// result; the next transaction is accepted once the block is back in idle.
// The RAM is 2^RAM_ADDR_BITS bytes, has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module banked_ram_bitmap_projection_top
    import brbp_pkg::*;
#(
    parameter int unsigned RAM_ADDR_BITS = 18
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic [23:0]              i_address,
    input  logic [7:0]               i_write_data,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_read_data,
    output logic                     o_read_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    t_cfg                     r_cfg;
    logic                     r_state;
    logic                     n_state;
    t_acc_info                r_info;
    logic [RAM_ADDR_BITS-1:0] r_addr;
    logic [7:0]               r_wdata;
    logic                     r_out_valid;
    logic [7:0]               r_read_data;
    logic                     r_read_valid;

    t_acc_info                w_info;
    logic [RAM_ADDR_BITS-1:0] w_map_addr;
    logic                     w_accept;
    logic                     w_finish;
    logic                     w_mem_en;
    logic                     w_mem_we;
    logic [RAM_ADDR_BITS-1:0] w_mem_addr;
    logic [7:0]               w_mem_wdata;
    logic [7:0]               w_rdata;
    logic [2:0]               w_sh;
    logic [7:0]               w_pmask;
    logic [7:0]               w_pix;
    logic [7:0]               w_merged;
    logic [7:0]               w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_bank   <= '0;
            r_cfg.cop_bank    <= '0;
            r_cfg.bitmap_mode <= 1'b0;
            r_cfg.two_bpp     <= 1'b0;
            r_cfg.ram_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HOST_BANK:   r_cfg.host_bank   <= i_cfg_data[4:0];
                REG_COP_BANK:    r_cfg.cop_bank    <= i_cfg_data;
                REG_BITMAP_MODE: r_cfg.bitmap_mode <= i_cfg_data[0];
                REG_TWO_BPP:     r_cfg.two_bpp     <= i_cfg_data[0];
                REG_RAM_PRESENT: r_cfg.ram_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    brbp_addr_map #(
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_addr_map (
        .i_cmd     (i_cmd),
        .i_address (i_address),
        .i_cfg     (r_cfg),
        .o_addr    (w_map_addr),
        .o_info    (w_info)
    );

    // handshake and sequencing
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_finish   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the decoded transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_info  <= w_info;
            r_addr  <= w_map_addr;
            r_wdata <= i_write_data;
        end
    end

    // pixel extract and merge on the byte read back
    assign w_sh     = r_info.two_bpp ? {r_info.pix_sel, 1'b0}
                                     : {r_info.pix_sel[0], 2'b00};
    assign w_pmask  = r_info.two_bpp ? PIX2_MASK : PIX4_MASK;
    assign w_pix    = (w_rdata >> w_sh) & w_pmask;
    assign w_merged = (w_rdata & ~(w_pmask << w_sh)) | ((r_wdata & w_pmask) << w_sh);

    always_comb begin
        priority if (!r_info.is_read) begin
            w_result = 8'd0;
        end else if (r_info.is_pixel) begin
            w_result = r_cfg.ram_present ? w_pix : 8'd0;
        end else begin
            w_result = r_cfg.ram_present ? w_rdata : r_wdata;
        end
    end

    // RAM: read at accept, write back when the transaction finishes
    assign w_mem_we    = w_finish && !r_info.is_read && r_cfg.ram_present;
    assign w_mem_en    = w_accept || w_mem_we;
    assign w_mem_addr  = w_mem_we ? r_addr : w_map_addr;
    assign w_mem_wdata = r_info.is_pixel ? w_merged : r_wdata;

    brbp_ram #(
        .ADDR_BITS (RAM_ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_read_data  <= w_result;
            r_read_valid <= r_info.is_read;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_read_valid = r_read_valid;

    // checks
    a_write_only_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_EXEC) && !w_accept)
        else $error("RAM write outside the finishing cycle");

    a_accept_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("accepted transaction did not enter execute");

    a_write_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_read_valid) |-> (o_read_data == 8'd0))
        else $error("write transaction returned nonzero data");

    a_finish_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> o_out_valid)
        else $error("finished transaction left no result");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banked byte RAM with bitmap projection. A short
// table of directed accesses comes first (extremes, every command, mirroring,
// pixel packing, no RAM fitted). Then come phases of random accesses, each
// under its own register settings and one of four sender and receiver idling mixes.
// A local model of the banking, the pixel packing and the RAM contents
// predicts every result. Results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brbp_pkg::*;

    localparam int unsigned RAM_BITS        = 18;
    localparam int unsigned RAM_BYTES       = 1 << RAM_BITS;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned NUM_PHASES      = 12;
    localparam int unsigned ITEMS_PER_PHASE = 120;
    localparam int unsigned REPORT_CAP      = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } t_read_result;

    typedef enum logic {ROW_ACCESS, ROW_CFG} t_row_kind;

    // one directed step: an access, or a register write (value in wdata)
    typedef struct packed {
        t_row_kind               kind;
        logic [1:0]              cmd;
        logic [23:0]             adr;
        logic [7:0]              wdata;
        logic [CFG_IDX_BITS-1:0] reg_idx;
        logic                    has_exp;
        logic [7:0]              exp_data;
        logic                    exp_valid;
    } t_stim_row;

    localparam int unsigned NUM_DIR_ROWS = 33;

    // cop_bank 0 in bitmap mode puts pixels of addresses 0..1 (four-bit) or 0..3 (two-bit) into byte 0
    localparam t_stim_row DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_ACCESS, CMD_HOST_WR, 24'h000000, 8'ha5, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'h000000, 8'h00, REG_HOST_BANK, 1'b1, 8'ha5, 1'b1},
        '{ROW_ACCESS, CMD_HOST_WR, 24'hffffff, 8'hff, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'hffffff, 8'h00, REG_HOST_BANK, 1'b1, 8'hff, 1'b1},
        // mirror of the top byte
        '{ROW_ACCESS, CMD_HOST_RD, 24'h03ffff, 8'h00, REG_HOST_BANK, 1'b1, 8'hff, 1'b1},
        '{ROW_ACCESS, CMD_HOST_WR, 24'h001fff, 8'h00, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h001fff, 8'h5a, REG_HOST_BANK, 1'b1, 8'h00, 1'b1},
        '{ROW_ACCESS, CMD_COP_WR,  24'hffe000, 8'h3c, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'h040000, 8'h00, REG_HOST_BANK, 1'b1, 8'h3c, 1'b1},
        '{ROW_ACCESS, CMD_COP_RD,  24'hffffff, 8'h00, REG_HOST_BANK, 1'b1, 8'h00, 1'b1},
        // four-bit pixels
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h01, REG_BITMAP_MODE, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000000, 8'hff, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000001, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_WR,  24'h000001, 8'hfa, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000001, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        // two-bit pixels
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h01, REG_TWO_BPP, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000003, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_WR,  24'h000000, 8'hff, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000000, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        // no RAM fitted: open bus on plain reads, zero on pixel reads
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h00, REG_RAM_PRESENT, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'h000000, 8'h5a, REG_HOST_BANK, 1'b1, 8'h5a, 1'b1},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000000, 8'h77, REG_HOST_BANK, 1'b1, 8'h00, 1'b1},
        '{ROW_ACCESS, CMD_COP_WR,  24'h000000, 8'h00, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_WR, 24'h000000, 8'h11, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h00, REG_BITMAP_MODE, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000123, 8'h99, REG_HOST_BANK, 1'b1, 8'h99, 1'b1},
        // RAM back: the dropped writes must not show
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h01, REG_RAM_PRESENT, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'h000000, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        // top banks
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h1f, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG,    CMD_HOST_RD, 24'h000000, 8'h7f, REG_COP_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_WR, 24'h000000, 8'h42, REG_HOST_BANK, 1'b1, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_COP_RD,  24'h000000, 8'h00, REG_HOST_BANK, 1'b0, 8'h00, 1'b0},
        '{ROW_ACCESS, CMD_HOST_RD, 24'h03e000, 8'h00, REG_HOST_BANK, 1'b1, 8'h42, 1'b1}
    };

    // DUT ports
    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data   = '0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_cmd        = CMD_HOST_RD;
    logic [23:0]              i_address    = '0;
    logic [7:0]               i_write_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic [7:0]               o_read_data;
    logic                     o_read_valid;

    // model state
    t_cfg         setting;
    bit [7:0]     ram_image  [RAM_BYTES];
    bit           ram_filled [RAM_BYTES];
    t_read_result pending_results [$];

    // traffic shaping
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    banked_ram_bitmap_projection_top #(
        .RAM_ADDR_BITS (RAM_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_read_valid (o_read_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // byte address that an access lands on, after banking and mirroring
    function automatic logic [RAM_BITS-1:0] byte_index(logic [1:0] cmd, logic [23:0] adr);
        logic [23:0] a;
        if (cmd == CMD_HOST_RD || cmd == CMD_HOST_WR) begin
            a = (adr < HOST_WINDOW) ? {6'd0, setting.host_bank, adr[12:0]} : adr;
        end else if (!setting.bitmap_mode) begin
            a = {6'd0, setting.cop_bank[4:0], adr[12:0]};
        end else begin
            a = {4'd0, setting.cop_bank, adr[12:0]};
            a = setting.two_bpp ? (a >> 2) : (a >> 1);
        end
        return a[RAM_BITS-1:0];
    endfunction

    // true when the access has to read a stored byte
    function automatic bit touches_ram(logic [1:0] cmd);
        return setting.ram_present && (cmd == CMD_HOST_RD || cmd == CMD_COP_RD ||
                                       (cmd == CMD_COP_WR && setting.bitmap_mode));
    endfunction

    // result of one access; applies its write to the RAM image
    function automatic t_read_result predict_access(logic [1:0] cmd, logic [23:0] adr,
                                                    logic [7:0] wd);
        t_read_result        res;
        logic [RAM_BITS-1:0] idx;
        logic [7:0]          cur;
        logic [7:0]          pix_mask;
        int unsigned         shift;
        res = '0;
        idx = byte_index(cmd, adr);
        cur = setting.ram_present ? ram_image[idx] : 8'h00;
        if (cmd == CMD_HOST_RD || cmd == CMD_HOST_WR || !setting.bitmap_mode) begin
            // whole bytes; reads with no RAM return the open-bus value
            if (cmd == CMD_HOST_RD || cmd == CMD_COP_RD) begin
                res.valid = 1'b1;
                res.data  = setting.ram_present ? cur : wd;
            end else if (setting.ram_present) begin
                ram_image[idx]  = wd;
                ram_filled[idx] = 1'b1;
            end
        end else begin
            // packed pixel: low address bits select the pixel within the byte
            pix_mask = setting.two_bpp ? PIX2_MASK : PIX4_MASK;
            shift    = setting.two_bpp ? 2 * adr[1:0] : 4 * adr[0];
            if (cmd == CMD_COP_RD) begin
                res.valid = 1'b1;
                res.data  = (cur >> shift) & pix_mask;
            end else if (setting.ram_present) begin
                ram_image[idx]  = (cur & ~(pix_mask << shift)) | ((wd & pix_mask) << shift);
                ram_filled[idx] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_BITS-1:0] idx,
                                          logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_HOST_BANK:   setting.host_bank   = val[4:0];
            REG_COP_BANK:    setting.cop_bank    = val[6:0];
            REG_BITMAP_MODE: setting.bitmap_mode = val[0];
            REG_TWO_BPP:     setting.two_bpp     = val[0];
            REG_RAM_PRESENT: setting.ram_present = val[0];
            default: ;
        endcase
    endfunction

    // called at a falling edge; the caller lowers the write enable afterwards
    task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        apply_setting(idx, val);
    endtask

    // stop offering, let every expected result come out, then a short settle
    task automatic wait_idle(input int unsigned settle);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // full register load; unused upper data bits carry random junk
    task automatic load_settings(input logic [4:0] hb, input logic [6:0] cb,
                                 input logic bm, input logic tb, input logic rp);
        wait_idle(SETTLE_CYCLES);
        write_setting(REG_HOST_BANK,   {2'($urandom), hb});
        write_setting(REG_COP_BANK,    cb);
        write_setting(REG_BITMAP_MODE, {6'($urandom), bm});
        write_setting(REG_TWO_BPP,     {6'($urandom), tb});
        write_setting(REG_RAM_PRESENT, {6'($urandom), rp});
        i_cfg_we <= 1'b0;
    endtask

    // one transaction on the input channel; entered and left at a falling edge
    task automatic offer(input logic [1:0] cmd, input logic [23:0] adr, input logic [7:0] wd,
                         input bit use_typed, input t_read_result typed);
        t_read_result pred;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_address    <= adr;
        i_write_data <= wd;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_access(cmd, adr, wd);
        pending_results.push_back(use_typed ? typed : pred);
        @(negedge i_clk);
    endtask

    // random access aimed at a few hot blocks so that bytes get reused
    task automatic pick_access(output logic [1:0] cmd, output logic [23:0] adr,
                               output logic [7:0] wd);
        logic [4:0]          blk;
        logic [RAM_BITS-1:0] idx;
        int unsigned         r;
        cmd = 2'($urandom_range(3));
        adr = 24'($urandom);
        wd  = 8'($urandom);
        case ($urandom_range(3))
            0:       blk = setting.host_bank;
            1:       blk = setting.cop_bank[4:0];
            2:       blk = setting.cop_bank[5:1];
            default: blk = setting.cop_bank[6:2];
        endcase
        r = $urandom_range(9);
        if (r < 3) adr[23:13] = '0;
        else if (r < 7) adr[17:13] = blk;
        r = $urandom_range(9);
        if (r < 5) adr[12:0] = 13'($urandom_range(31));
        else if (r < 7) adr[12:0] = 13'h1fe0 | 13'($urandom_range(31));
        // an access to a byte that was never written becomes a host write of that byte instead
        idx = byte_index(cmd, adr);
        if (touches_ram(cmd) && !ram_filled[idx]) begin
            cmd = CMD_HOST_WR;
            adr = 24'($urandom);
            adr[RAM_BITS-1:0] = idx;
            if (adr < HOST_WINDOW) adr[RAM_BITS] = 1'b1;
        end
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker and run limit
    always @(posedge i_clk) begin
        t_read_result exp_res;
        cycle_count++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result transaction with nothing expected: data %02h valid %0b",
                             $time, o_read_data, o_read_valid);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_read_data !== exp_res.data) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: read_data mismatch: expected %02h, got %02h",
                                 $time, exp_res.data, o_read_data);
                end
                if (o_read_valid !== exp_res.valid) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: read_valid mismatch: expected %0b, got %0b",
                                 $time, exp_res.valid, o_read_valid);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("** banked_ram_bitmap_projection_top: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [1:0]  cmd;
        logic [23:0] adr;
        logic [7:0]  wd;
        setting.host_bank   = '0;
        setting.cop_bank    = '0;
        setting.bitmap_mode = 1'b0;
        setting.two_bpp     = 1'b0;
        setting.ram_present = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                wait_idle(SETTLE_CYCLES);
                write_setting(DIR_ROWS[i].reg_idx, 7'(DIR_ROWS[i].wdata));
                i_cfg_we <= 1'b0;
            end else begin
                offer(DIR_ROWS[i].cmd, DIR_ROWS[i].adr, DIR_ROWS[i].wdata,
                      DIR_ROWS[i].has_exp, {DIR_ROWS[i].exp_data, DIR_ROWS[i].exp_valid});
            end
        end

        // random phases; the first few pin the register extremes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       load_settings(5'd0,  7'd0,   1'b0, 1'b0, 1'b1);
                1:       load_settings(5'd31, 7'd127, 1'b1, 1'b1, 1'b1);
                2:       load_settings(5'd31, 7'd0,   1'b1, 1'b0, 1'b1);
                3:       load_settings(5'd0,  7'd127, 1'b0, 1'b1, 1'b0);
                default: load_settings(5'($urandom), 7'($urandom), 1'($urandom),
                                       1'($urandom), $urandom_range(7) != 0);
            endcase
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 74; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 74; end
                default: begin send_gap_pct = 37; recv_stall_pct = 37; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (ph == 4 || ph == 9) holds_asked++;
            repeat (ITEMS_PER_PHASE) begin
                pick_access(cmd, adr, wd);
                offer(cmd, adr, wd, 1'b0, '0);
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0) begin
            $display("** banked_ram_bitmap_projection_top: PASSED **");
        end else begin
            $display("** banked_ram_bitmap_projection_top: FAILED **");
        end
        $finish;
    end

endmodule
